// File: rtl/core/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define RLR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define RLR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/rlr_pkg.sv
// Shared constants, types and codes of the run-level requantizer
`default_nettype none

package rlr_pkg;

  localparam int BLOCK_COEFFS = 64;

  localparam int RUN_W    = 7;
  localparam int LEVEL_W  = 12;
  localparam int MAG_W    = 11;
  localparam int SCALE_W  = 7;
  localparam int PROD_W   = LEVEL_W + SCALE_W;
  localparam int ERR_W    = 29;
  localparam int DIFF_W   = SCALE_W + 1;
  localparam int TERM_W   = 2 * DIFF_W;

  localparam int LEVEL_MAX = 2047;
  localparam logic [ERR_W-1:0]   ERR_MAX     = {ERR_W{1'b1}};
  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(2);

  // restoring divide: one quotient bit per cycle
  localparam int DIV_STEPS = MAG_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_OLD_SCALE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NEW_SCALE = CFG_IDX_W'(1);

  // classified coefficient handed from front to back
  typedef struct packed {
    logic [RUN_W-1:0] run;
    logic [MAG_W-1:0] satm;   // saturated |level| * old_scale
    logic             neg;
    logic             extra;  // negative side saturates one step further
    logic             last;
  } rlr_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SQR,
    BK_DONE
  } rlr_bk_state_t;

endpackage

`default_nettype wire

// File: rtl/core/rlr_if.sv
// Valid/ready channel interfaces for coefficient input and result output
`default_nettype none

interface rlr_in_if;
  import rlr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [RUN_W-1:0]          run_distance;
  logic signed [LEVEL_W-1:0] coeff_level;
  logic                      block_end;

  modport source (output valid, output run_distance, output coeff_level,
                  output block_end, input ready);
  modport sink   (input valid, input run_distance, input coeff_level,
                  input block_end, output ready);
endinterface

interface rlr_out_if;
  import rlr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [RUN_W-1:0]          out_run;
  logic signed [LEVEL_W-1:0] out_level;
  logic                      present;
  logic                      is_last;
  logic [ERR_W-1:0]          block_error;

  modport source (output valid, output out_run, output out_level, output present,
                  output is_last, output block_error, input ready);
  modport sink   (input valid, input out_run, input out_level, input present,
                  input is_last, input block_error, output ready);
endinterface

`default_nettype wire

// File: rtl/core/rlr_front.sv
// Front end: accepts coefficient beats, scales and saturates the magnitude
`default_nettype none

module rlr_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [rlr_pkg::SCALE_W-1:0]  old_scale,
  rlr_in_if.sink                       in_chan,
  output rlr_pkg::rlr_entry_t          ent,
  output logic                         ent_valid,
  input  logic                         ent_ready
);
  import rlr_pkg::*;

  logic                fr_valid_r, fr_valid_nxt;
  rlr_entry_t          ent_r;
  logic                accept;
  logic                neg;
  logic [LEVEL_W-1:0]  lvl_u;
  logic [LEVEL_W-1:0]  mag;
  logic [PROD_W-1:0]   prod;
  logic                over;

  assign in_chan.ready = !fr_valid_r || ent_ready;
  assign accept        = in_chan.valid && in_chan.ready;

  // -2048 comes out as 2048, which fits unsigned
  assign lvl_u = $unsigned(in_chan.coeff_level);
  assign neg   = lvl_u[LEVEL_W-1];
  assign mag   = neg ? (~lvl_u + LEVEL_W'(1)) : lvl_u;
  assign prod  = PROD_W'(mag) * PROD_W'(old_scale);
  assign over  = prod > PROD_W'(LEVEL_MAX);

  always_comb begin
    fr_valid_nxt = fr_valid_r;
    if (accept) begin
      fr_valid_nxt = 1'b1;
    end else if (ent_ready) begin
      fr_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_valid_r <= 1'b0;
    end else begin
      fr_valid_r <= fr_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ent_r.run   <= in_chan.run_distance;
      ent_r.satm  <= over ? MAG_W'(LEVEL_MAX) : prod[MAG_W-1:0];
      ent_r.neg   <= neg;
      ent_r.extra <= neg && over;
      ent_r.last  <= in_chan.block_end;
    end
  end

  assign ent       = ent_r;
  assign ent_valid = fr_valid_r;

endmodule

`default_nettype wire

// File: rtl/core/rlr_queue.sv
// Short FIFO between front and back ends
`default_nettype none

module rlr_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rlr_pkg::rlr_entry_t  push_data,
  input  logic                 push_valid,
  output logic                 push_ready,
  output rlr_pkg::rlr_entry_t  pop_data,
  output logic                 pop_valid,
  input  logic                 pop_ready
);
  import rlr_pkg::*;

  rlr_entry_t          slot_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CW-1:0] count_r, count_nxt;
  logic                do_push, do_pop;

  assign push_ready = count_r != QUEUE_CW'(QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;
  assign pop_data   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QUEUE_AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QUEUE_AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QUEUE_CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QUEUE_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/rlr_back.sv
// Back end: iterative divide, error accumulation, run carry and result register
`default_nettype none

module rlr_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [rlr_pkg::SCALE_W-1:0]  new_scale,
  input  rlr_pkg::rlr_entry_t          ent,
  input  logic                         ent_valid,
  output logic                         ent_pop,
  rlr_out_if.source                    out_chan
);
  import rlr_pkg::*;

  rlr_bk_state_t        state_r, state_nxt;

  rlr_entry_t           cur_r;
  logic [SCALE_W-1:0]   rem_r;
  logic [MAG_W-1:0]     dvd_r;    // dividend in, quotient out
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [TERM_W-1:0]    term_r;
  logic [RUN_W-1:0]     pend_r;
  logic [ERR_W-1:0]     err_r;

  logic                 out_valid_r;
  logic [RUN_W-1:0]     out_run_r;
  logic [LEVEL_W-1:0]   out_level_r;
  logic                 present_r;
  logic                 is_last_r;
  logic [ERR_W-1:0]     block_error_r;

  logic [SCALE_W-1:0]   divisor;
  logic [SCALE_W:0]     trial;
  logic                 ge;
  logic [DIFF_W-1:0]    diff;
  logic [ERR_W:0]       err_sum;
  logic [ERR_W-1:0]     err_nxt;
  logic [RUN_W:0]       dist_sum;
  logic [RUN_W-1:0]     run_dist;
  logic                 kept;
  logic                 need_out;
  logic                 out_free;
  logic [LEVEL_W-1:0]   qlev;

  logic                 do_load, do_step, do_sqr, do_commit;

  assign divisor = (new_scale == '0) ? SCALE_W'(1) : new_scale;
  assign trial   = {rem_r, dvd_r[MAG_W-1]};
  assign ge      = trial >= {1'b0, divisor};

  // |error| is the remainder, plus one where the negative side saturated at -2048
  assign diff    = DIFF_W'(rem_r) + DIFF_W'(cur_r.extra);

  assign err_sum = (ERR_W+1)'(err_r) + (ERR_W+1)'(term_r);
  assign err_nxt = err_sum[ERR_W] ? ERR_MAX : err_sum[ERR_W-1:0];

  assign dist_sum = (RUN_W+1)'(pend_r) + (RUN_W+1)'(cur_r.run);
  assign run_dist = (dist_sum > (RUN_W+1)'(BLOCK_COEFFS)) ? RUN_W'(BLOCK_COEFFS)
                                                          : dist_sum[RUN_W-1:0];

  assign kept     = dvd_r != '0;
  assign need_out = kept || cur_r.last;
  assign out_free = !out_valid_r || out_chan.ready;
  assign qlev     = LEVEL_W'(dvd_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: if (ent_valid) state_nxt = BK_DIV;
      BK_DIV:  if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) state_nxt = BK_SQR;
      BK_SQR:  state_nxt = BK_DONE;
      BK_DONE: if (!need_out || out_free) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    do_load   = 1'b0;
    do_step   = 1'b0;
    do_sqr    = 1'b0;
    do_commit = 1'b0;
    case (state_r)
      BK_IDLE: do_load   = ent_valid;
      BK_DIV:  do_step   = 1'b1;
      BK_SQR:  do_sqr    = 1'b1;
      BK_DONE: do_commit = !need_out || out_free;
      default: ;
    endcase
  end

  assign ent_pop = do_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      pend_r      <= '0;
      err_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (do_commit) begin
        pend_r <= (kept || cur_r.last) ? '0 : run_dist;
        err_r  <= cur_r.last ? '0 : err_nxt;
      end
      if (do_commit && need_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      cur_r <= ent;
      dvd_r <= ent.satm;
      rem_r <= '0;
      cnt_r <= '0;
    end
    if (do_step) begin
      rem_r <= ge ? SCALE_W'(trial - {1'b0, divisor}) : trial[SCALE_W-1:0];
      dvd_r <= {dvd_r[MAG_W-2:0], ge};
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
    if (do_sqr) begin
      term_r <= TERM_W'(diff) * TERM_W'(diff);
    end
    if (do_commit && need_out) begin
      out_run_r     <= kept ? run_dist : '0;
      out_level_r   <= !kept ? '0 : (cur_r.neg ? (~qlev + LEVEL_W'(1)) : qlev);
      present_r     <= kept;
      is_last_r     <= cur_r.last;
      block_error_r <= cur_r.last ? err_nxt : '0;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.out_run     = out_run_r;
  assign out_chan.out_level   = $signed(out_level_r);
  assign out_chan.present     = present_r;
  assign out_chan.is_last     = is_last_r;
  assign out_chan.block_error = block_error_r;

endmodule

`default_nettype wire

// File: rtl/core/run_level_requantizer.sv
// Top level of the run-level requantizer: config registers, front, queue, back
// An input beat passes the front register, the queue and the back end's load,
// divide, square and accumulate steps. The back end works on one coefficient at
// a time, with an 11-step restoring divider, and pops no new entry until done.
// The front takes new beats into a two-entry queue while the back is busy.
// Reset (rst_n low, synchronous): scales go to 2, run carry and error sum to 0,
// queue and result register empty; no clearing pass.
`default_nettype none

module run_level_requantizer (
  input  logic                          clk,
  input  logic                          rst_n,
  rlr_in_if.sink                        in_chan,
  rlr_out_if.source                     out_chan,
  input  logic                          cfg_we,
  input  logic [rlr_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [rlr_pkg::SCALE_W-1:0]   cfg_data
);
  import rlr_pkg::*;

  logic [SCALE_W-1:0] old_scale_r;
  logic [SCALE_W-1:0] new_scale_r;

  rlr_entry_t fr_ent;
  logic       fr_valid;
  logic       fr_ready;
  rlr_entry_t q_ent;
  logic       q_valid;
  logic       q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      old_scale_r <= SCALE_RESET;
      new_scale_r <= SCALE_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_OLD_SCALE: old_scale_r <= cfg_data;
        REG_NEW_SCALE: new_scale_r <= cfg_data;
        default: ;
      endcase
    end
  end

  rlr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .old_scale (old_scale_r),
    .in_chan   (in_chan),
    .ent       (fr_ent),
    .ent_valid (fr_valid),
    .ent_ready (fr_ready)
  );

  rlr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_data  (fr_ent),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .pop_data   (q_ent),
    .pop_valid  (q_valid),
    .pop_ready  (q_pop)
  );

  rlr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .new_scale (new_scale_r),
    .ent       (q_ent),
    .ent_valid (q_valid),
    .ent_pop   (q_pop),
    .out_chan  (out_chan)
  );

endmodule

`default_nettype wire

// File: rtl/core/rlr_checker.sv
// Port-level checks on the result channel, bound to the top level
`default_nettype none

`include "assert_macros.svh"

module rlr_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [rlr_pkg::RUN_W-1:0]          out_run,
  input logic signed [rlr_pkg::LEVEL_W-1:0] out_level,
  input logic                               present,
  input logic                               is_last,
  input logic [rlr_pkg::ERR_W-1:0]          block_error
);
  import rlr_pkg::*;

  // a stalled result beat stays up
  `RLR_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result beat dropped while stalled")

  // an empty beat only ever closes a block
  `RLR_ASSERT_IMP(a_empty_closes, clk, rst_n, out_valid && !present, is_last && out_run == '0 && out_level == '0, "empty beat not a clean block close")

  // a kept coefficient never carries a zero level
  `RLR_ASSERT_IMP(a_kept_nonzero, clk, rst_n, out_valid && present, out_level != '0, "kept beat with zero level")

  // error total only on the closing beat
  `RLR_ASSERT_IMP(a_err_on_last, clk, rst_n, out_valid && !is_last, block_error == '0, "block error outside the closing beat")

endmodule

bind run_level_requantizer rlr_checker u_rlr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_run     (out_chan.out_run),
  .out_level   (out_chan.out_level),
  .present     (out_chan.present),
  .is_last     (out_chan.is_last),
  .block_error (out_chan.block_error)
);

`default_nettype wire
